// File: design/fal_pkg.sv
package fal_pkg;

  localparam int unsigned OpW  = 16;
  localparam int unsigned SumW = 49;
  localparam int unsigned LcmW = 32;
  localparam int unsigned WhlW = 17;

  localparam logic [2:0] FORM_WHOLE    = 3'd0;
  localparam logic [2:0] FORM_SAME     = 3'd1;
  localparam logic [2:0] FORM_MIXED    = 3'd2;
  localparam logic [2:0] FORM_PROPER   = 3'd3;
  localparam logic [2:0] FORM_ZERO_DEN = 3'd4;

  typedef struct packed {
    logic [OpW-1:0] num_a;
    logic [OpW-1:0] den_a;
    logic [OpW-1:0] num_b;
    logic [OpW-1:0] den_b;
  } fal_in_t;

  typedef struct packed {
    logic [2:0]      form;
    logic [SumW-1:0] sum_numerator;
    logic [LcmW-1:0] common_denominator;
    logic [WhlW-1:0] whole_part;
    logic [LcmW-1:0] remainder_numerator;
  } fal_out_t;

  // datapath operations
  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_GSTEP = 3'd1;  // start gcd remainder division
  localparam logic [2:0] OP_LCM1  = 3'd2;  // start da / g
  localparam logic [2:0] OP_LCM2  = 3'd3;  // hold da / g, start db / g
  localparam logic [2:0] OP_MUL   = 3'd4;  // lcm and both scaled numerators
  localparam logic [2:0] OP_SUM   = 3'd5;
  localparam logic [2:0] OP_FDIV  = 3'd6;  // start sum / lcm
  localparam logic [2:0] OP_IDLE  = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic       shift;  // advance divider one bit
    logic       gswap;  // x <= y, y <= remainder
    logic       fin;    // register the result
  } fal_cmd_t;

  typedef struct packed {
    logic zero_den;
    logic same_den;
    logic y_zero;
    logic div_done;
  } fal_sts_t;

endpackage

// File: design/fal_datapath.sv
module fal_datapath import fal_pkg::*; (
  input  logic     clk_i,
  input  fal_in_t  in_i,
  input  fal_cmd_t cmd_i,
  output fal_sts_t sts_o,
  output fal_out_t res_o
);

  logic [OpW-1:0]  na_q, da_q, nb_q, db_q, x_q, y_q, dg_q;
  logic [LcmW-1:0] lcm_q, pa_q, pb_q;
  logic [SumW-1:0] sum_q;
  // shared restoring divider, 49-bit dividend, 32-bit divisor
  logic [SumW-1:0] dq_q;
  logic [LcmW:0]   dr_q;
  logic [LcmW-1:0] dv_q;
  logic [5:0]      dc_q;
  logic [LcmW:0]   trial;
  logic [LcmW+1:0] diff;
  fal_out_t        res_q, res_d;

  assign trial = {dr_q[LcmW-1:0], dq_q[SumW-1]};
  assign diff  = {1'b0, trial} - {2'b0, dv_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      dq_q <= {dq_q[SumW-2:0], ~diff[LcmW+1]};
      dr_q <= diff[LcmW+1] ? trial : diff[LcmW:0];
      dc_q <= dc_q - 6'd1;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        na_q <= in_i.num_a; da_q <= in_i.den_a;
        nb_q <= in_i.num_b; db_q <= in_i.den_b;
        x_q <= in_i.den_a; y_q <= in_i.den_b;
      end
      OP_GSTEP: begin
        dq_q <= {x_q, {(SumW-OpW){1'b0}}}; dr_q <= '0;
        dv_q <= LcmW'(y_q); dc_q <= 6'(OpW);
      end
      OP_LCM1: begin
        dq_q <= {da_q, {(SumW-OpW){1'b0}}}; dr_q <= '0;
        dv_q <= LcmW'(x_q); dc_q <= 6'(OpW);
      end
      OP_LCM2: begin
        dg_q <= dq_q[OpW-1:0];
        dq_q <= {db_q, {(SumW-OpW){1'b0}}}; dr_q <= '0;
        dv_q <= LcmW'(x_q); dc_q <= 6'(OpW);
      end
      OP_MUL: begin
        // lcm/da = db/g (quotient in dq_q), lcm/db = da/g
        lcm_q <= LcmW'(dg_q) * LcmW'(db_q);
        pa_q  <= LcmW'(dq_q[OpW-1:0]) * LcmW'(na_q);
        pb_q  <= LcmW'(dg_q) * LcmW'(nb_q);
      end
      OP_SUM: begin
        sum_q <= SumW'(pa_q) + SumW'(pb_q);
      end
      OP_FDIV: begin
        dq_q <= sum_q; dr_q <= '0; dv_q <= lcm_q; dc_q <= 6'(SumW);
      end
      default: ;
    endcase
    if (cmd_i.gswap) begin
      x_q <= y_q; y_q <= dr_q[OpW-1:0];
    end
    if (cmd_i.fin) res_q <= res_d;
  end

  always_comb begin
    res_d = '0;
    if (sts_o.zero_den) res_d.form = FORM_ZERO_DEN;
    else if (sts_o.same_den) begin
      res_d.common_denominator = LcmW'(da_q);
      res_d.sum_numerator = SumW'(na_q) + SumW'(nb_q);
      if (res_d.sum_numerator == SumW'(da_q)) begin
        res_d.form = FORM_WHOLE; res_d.whole_part = WhlW'(1);
      end else res_d.form = FORM_SAME;
    end else begin
      res_d.common_denominator = lcm_q;
      res_d.sum_numerator = sum_q;
      if (dr_q == '0) begin
        res_d.form = FORM_WHOLE; res_d.whole_part = dq_q[WhlW-1:0];
      end else if (dq_q != '0) begin
        res_d.form = FORM_MIXED; res_d.whole_part = dq_q[WhlW-1:0];
        res_d.remainder_numerator = dr_q[LcmW-1:0];
      end else res_d.form = FORM_PROPER;
    end
  end

  assign sts_o.zero_den = (da_q == '0) || (db_q == '0);
  assign sts_o.same_den = da_q == db_q;
  assign sts_o.y_zero   = y_q == '0;
  assign sts_o.div_done = dc_q == 6'd0;
  assign res_o = res_q;
endmodule

// File: design/fal_ctrl.sv
module fal_ctrl import fal_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  fal_sts_t sts_i,
  output fal_cmd_t cmd_o,
  output logic     busy_o,
  output logic     valid_o
);
  localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_GDIV = 4'd2, S_LDIV = 4'd3,
    S_LDIV2 = 4'd4, S_MUL = 4'd5, S_SUM = 4'd6, S_FDIV = 4'd7, S_OUT = 4'd8;
  logic [3:0] st_q, st_d;
  logic       v_q, v_d;

  always_comb begin
    st_d = st_q; v_d = 1'b0;
    cmd_o = '{op: OP_IDLE, shift: 1'b0, gswap: 1'b0, fin: 1'b0};
    case (st_q)
      S_IDLE: if (start_i) begin cmd_o.op = OP_LOAD; st_d = S_CHK; end
      S_CHK: begin
        if (sts_i.zero_den || sts_i.same_den) begin
          cmd_o.fin = 1'b1; st_d = S_OUT;
        end else if (sts_i.y_zero) begin
          cmd_o.op = OP_LCM1; st_d = S_LDIV;
        end else begin
          cmd_o.op = OP_GSTEP; st_d = S_GDIV;
        end
      end
      S_GDIV: if (sts_i.div_done) begin
        cmd_o.gswap = 1'b1; st_d = S_CHK;
      end else cmd_o.shift = 1'b1;
      S_LDIV: if (sts_i.div_done) begin
        cmd_o.op = OP_LCM2; st_d = S_LDIV2;
      end else cmd_o.shift = 1'b1;
      S_LDIV2: if (sts_i.div_done) begin
        cmd_o.op = OP_MUL; st_d = S_MUL;
      end else cmd_o.shift = 1'b1;
      S_MUL: begin cmd_o.op = OP_SUM; st_d = S_SUM; end
      S_SUM: begin cmd_o.op = OP_FDIV; st_d = S_FDIV; end
      S_FDIV: if (sts_i.div_done) begin
        cmd_o.fin = 1'b1; st_d = S_OUT;
      end else cmd_o.shift = 1'b1;
      S_OUT: begin v_d = 1'b1; st_d = S_IDLE; end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; v_q <= 1'b0;
    end else begin
      st_q <= st_d; v_q <= v_d;
    end
  end
  assign busy_o  = st_q != S_IDLE;
  assign valid_o = v_q;
endmodule

// File: design/fraction_adder_lcm_core.sv
// Adds two fractions; raise start and hold it with the operands until busy is
// low at a clock edge. valid_o is high for one cycle with the result on result_o;
// the receiver cannot stall. One shared bit-serial divider does each Euclid step
// for the 16-bit denominators, then each of the two quotients by the GCD, then
// the final division. Zero or equal denominators skip the divider.
module fraction_adder_lcm_core import fal_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  fal_in_t  operands_i,
  output logic     valid_o,
  output fal_out_t result_o
);
  fal_cmd_t cmd;
  fal_sts_t sts;
  logic     st_go;
  assign st_go = start && !busy;

  fal_ctrl u_ctrl (.clk_i, .rst_ni, .start_i(st_go), .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy), .valid_o);
  fal_datapath u_dp (.clk_i, .in_i(operands_i), .cmd_i(cmd), .sts_o(sts),
    .res_o(result_o));
endmodule
